### src/smeu_pkg.sv
// Package with opcodes, status codes, sizes and shared types of the stack machine execute unit.
package smeu_pkg;

  localparam int DATA_STACK_DEPTH   = 64;
  localparam int RETURN_STACK_DEPTH = 16;
  localparam int REG_COUNT          = 8;
  localparam int RAM_WORDS          = 256;
  localparam int PROGRAM_WORDS      = 1024;

  localparam int DS_AW  = $clog2(DATA_STACK_DEPTH);
  localparam int DS_DW  = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RS_AW  = $clog2(RETURN_STACK_DEPTH);
  localparam int RS_DW  = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int REG_AW = $clog2(REG_COUNT);
  localparam int RAM_AW = $clog2(RAM_WORDS);
  localparam int PC_W   = 10;

  localparam logic [4:0] OP_PUSH  = 5'd0;
  localparam logic [4:0] OP_OUT   = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_SUB   = 5'd3;
  localparam logic [4:0] OP_DIV   = 5'd4;
  localparam logic [4:0] OP_MUL   = 5'd5;
  localparam logic [4:0] OP_SQRT  = 5'd6;
  localparam logic [4:0] OP_IN    = 5'd7;
  localparam logic [4:0] OP_POPR  = 5'd8;
  localparam logic [4:0] OP_PUSHR = 5'd9;
  localparam logic [4:0] OP_JMP   = 5'd10;
  localparam logic [4:0] OP_JE    = 5'd11;
  localparam logic [4:0] OP_JNE   = 5'd12;
  localparam logic [4:0] OP_JA    = 5'd13;
  localparam logic [4:0] OP_JAE   = 5'd14;
  localparam logic [4:0] OP_JB    = 5'd15;
  localparam logic [4:0] OP_JBE   = 5'd16;
  localparam logic [4:0] OP_CALL  = 5'd17;
  localparam logic [4:0] OP_RET   = 5'd18;
  localparam logic [4:0] OP_PUSHM = 5'd19;
  localparam logic [4:0] OP_POPM  = 5'd20;
  localparam logic [4:0] OP_NOP   = 5'd21;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_NEG   = 3'd4;
  localparam logic [2:0] ST_INDEX = 3'd5;
  localparam logic [2:0] ST_RET   = 3'd6;

  // Request to the iterative divide and square root unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [31:0] a;
    logic [31:0] b;
  } smeu_iter_req_t;

endpackage

### src/smeu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/smeu_iter.sv
// Iterative signed divider and integer square root, one bit or one root digit per cycle.
module smeu_iter
  import smeu_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  smeu_iter_req_t req,
  output logic           done,
  output logic [31:0]    result
);

  logic        busy_r, busy_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [33:0] strial;
  logic [33:0] srem;

  assign done   = done_r;
  assign result = neg_r ? (32'd0 - quo_r) : quo_r;

  // One quotient bit or one root bit each cycle; sqrt consumes two radicand bits per step.
  always_comb begin
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], num_r[31]};
    srem     = {rem_r[31:0], num_r[31:30]};
    strial   = srem - {quo_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      rem_nxt  = '0;
      quo_nxt  = '0;
      if (req.is_sqrt) begin
        cnt_nxt = 6'd16;
        num_nxt = req.a;
        neg_nxt = 1'b0;
      end else begin
        cnt_nxt = 6'd32;
        num_nxt = req.a[31] ? (32'd0 - req.a) : req.a;
        den_nxt = req.b[31] ? (32'd0 - req.b) : req.b;
        neg_nxt = req.a[31] ^ req.b[31];
      end
    end else if (busy_r) begin
      if (sqrt_r) begin
        num_nxt = {num_r[29:0], 2'b00};
        if (!strial[33]) begin
          rem_nxt = strial[32:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = srem[32:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end else begin
        num_nxt = {num_r[30:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = trial - {1'b0, den_r};
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

### src/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer, stack memories and result register.
//
// The unit executes one instruction per request and returns one result per request.
// The top two data stack entries are kept in registers; the rest of the data stack,
// the return stack and the data memory are synchronous RAMs. Most instructions pass from
// acceptance through the execute state to the done state, which raises the output valid.
// A pop that exposes a cached slot also passes through the fill state, where the second
// slot is refilled from the stack RAM; a conditional jump that drops two entries with
// more below passes through it to address and then to read the new second slot. Divide
// and square root wait in the iterative state on the shared one-bit-per-cycle unit. After
// reset the data memory is cleared word by word before the first request is accepted.
// A new request is taken only when the unit is idle and the previous result has been
// taken, so the earliest next acceptance is the cycle after the result handshake.
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: req_type[4:0], operand[36:5], input_value[68:37], zero pad to 72 bits
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: next_pc[9:0], out_valid[10], out_value[42:11], status[45:43],
  // completed_count[77:46], zero pad to 80 bits
  output logic [79:0] out_tdata
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_FILL  = 6'b001000,
    S_ITER  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Request latch.
  logic [4:0]  op_r;
  logic [31:0] arg_r, inval_r;

  // Architectural state in flip-flops.
  logic [DS_DW-1:0]  dd_r, dd_nxt;
  logic [RS_DW-1:0]  rd_r, rd_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [31:0]       cc_r, cc_nxt;
  logic [31:0]       regs_r [REG_COUNT];
  logic [31:0]       top_r, top_nxt, sec_r, sec_nxt;
  logic [RAM_AW:0]   clr_r, clr_nxt;
  logic [1:0]        fill_r, fill_nxt;

  // Output register.
  logic        ovld_r, ovld_nxt;
  logic [79:0] odata_r, odata_nxt;

  // Memory ports.
  logic              ds_we;
  logic [DS_AW-1:0]  ds_waddr, ds_raddr;
  logic [31:0]       ds_wdata, ds_rdata;
  logic              rs_we;
  logic [RS_AW-1:0]  rs_waddr, rs_raddr;
  logic [PC_W-1:0]   rs_wdata, rs_rdata;
  logic              mm_we;
  logic [RAM_AW-1:0] mm_waddr, mm_raddr;
  logic [31:0]       mm_wdata, mm_rdata;

  smeu_iter_req_t ireq;
  logic           idone;
  logic [31:0]    ires;

  // Execute-stage decode results.
  logic              reg_we;
  logic [REG_AW-1:0] reg_wa;
  logic [31:0]       reg_wd;
  logic [2:0]        status;
  logic [PC_W-1:0]   npc;
  logic              ovalid;
  logic [31:0]       oval;
  logic              cnt_en;
  logic [PC_W-1:0]   next1, next2;
  logic              reg_ok, tgt_ok, addr_ok;
  logic [31:0]       rval;
  logic              take;
  logic              full, has1, has2;

  smeu_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_ds (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );
  smeu_ram #(.WIDTH(PC_W), .DEPTH(RETURN_STACK_DEPTH)) u_rs (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );
  smeu_ram #(.WIDTH(32), .DEPTH(RAM_WORDS)) u_mem (
    .clk(clk), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
    .raddr(mm_raddr), .rdata(mm_rdata)
  );
  smeu_iter u_iter (.clk(clk), .rst_n(rst_n), .req(ireq), .done(idone), .result(ires));

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  assign full   = (dd_r == DS_DW'(DATA_STACK_DEPTH));
  assign has1   = (dd_r != '0);
  assign has2   = (dd_r > DS_DW'(1));
  assign next1  = pc_r + PC_W'(1);
  assign next2  = pc_r + PC_W'(2);
  assign reg_ok = (arg_r < 32'(REG_COUNT));
  assign tgt_ok = (arg_r < 32'(PROGRAM_WORDS));
  assign rval   = regs_r[arg_r[REG_AW-1:0]];
  assign addr_ok = (rval < 32'(RAM_WORDS));

  // Memory read addresses: the entry below the second cache slot, the return top,
  // and the data word addressed by the register operand. While idle the data word
  // is addressed from the incoming request so that it is ready in the execute cycle.
  // While the iterative unit runs or a compare pop fills, the refill entry is addressed ahead.
  always_comb begin
    ds_raddr = DS_AW'(dd_r - DS_DW'(3));
    if ((state_r == S_FILL && fill_r == 2'd2) || state_r == S_ITER) begin
      ds_raddr = DS_AW'(dd_r - DS_DW'(2));
    end
    rs_raddr = RS_AW'(rd_r - RS_DW'(1));
    mm_raddr = rval[RAM_AW-1:0];
    if (state_r == S_IDLE) begin
      mm_raddr = regs_r[in_tdata[5 +: REG_AW]][RAM_AW-1:0];
    end
  end

  // Compare of the element below the top against the top.
  always_comb begin
    case (op_r)
      OP_JE:   take = (sec_r == top_r);
      OP_JNE:  take = (sec_r != top_r);
      OP_JA:   take = ($signed(sec_r) >  $signed(top_r));
      OP_JAE:  take = ($signed(sec_r) >= $signed(top_r));
      OP_JB:   take = ($signed(sec_r) <  $signed(top_r));
      OP_JBE:  take = ($signed(sec_r) <= $signed(top_r));
      default: take = 1'b1;
    endcase
  end

  // Main sequencer: the execute cycle decides status and state changes; pops that
  // expose a cached slot refill it from the stack RAM in the fill cycles.
  always_comb begin
    state_nxt = state_r;
    dd_nxt    = dd_r;
    rd_nxt    = rd_r;
    pc_nxt    = pc_r;
    cc_nxt    = cc_r;
    top_nxt   = top_r;
    sec_nxt   = sec_r;
    clr_nxt   = clr_r;
    fill_nxt  = fill_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;
    ds_we     = 1'b0;
    ds_waddr  = DS_AW'(dd_r - DS_DW'(2));
    ds_wdata  = sec_r;
    rs_we     = 1'b0;
    rs_waddr  = RS_AW'(rd_r);
    rs_wdata  = next2;
    mm_we     = 1'b0;
    mm_waddr  = rval[RAM_AW-1:0];
    mm_wdata  = top_r;
    reg_we    = 1'b0;
    reg_wa    = arg_r[REG_AW-1:0];
    reg_wd    = top_r;
    ireq      = '{start: 1'b0, is_sqrt: 1'b0, a: sec_r, b: top_r};
    status    = ST_OK;
    npc       = pc_r;
    ovalid    = 1'b0;
    oval      = '0;
    cnt_en    = 1'b1;

    if (out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mm_we    = 1'b1;
        mm_waddr = clr_r[RAM_AW-1:0];
        mm_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == (RAM_AW+1)'(RAM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        fill_nxt  = 2'd0;
        state_nxt = S_DONE;
        case (op_r)
          OP_PUSH, OP_IN, OP_PUSHR, OP_PUSHM: begin
            if ((op_r == OP_PUSHR || op_r == OP_PUSHM) && !reg_ok) begin
              status = ST_INDEX;
            end else if (op_r == OP_PUSHM && !addr_ok) begin
              status = ST_INDEX;
            end else if (full) begin
              status = ST_FULL;
            end else begin
              if (dd_r > DS_DW'(1)) begin
                ds_we = 1'b1;
              end
              sec_nxt = top_r;
              dd_nxt  = dd_r + DS_DW'(1);
              case (op_r)
                OP_PUSH:  top_nxt = arg_r;
                OP_IN:    top_nxt = inval_r;
                OP_PUSHR: top_nxt = rval;
                default:  top_nxt = mm_rdata;
              endcase
              npc = (op_r == OP_IN) ? next1 : next2;
            end
          end
          OP_OUT, OP_POPR, OP_POPM: begin
            if (op_r != OP_OUT && !reg_ok) begin
              status = ST_INDEX;
            end else if (op_r == OP_POPM && !addr_ok) begin
              status = ST_INDEX;
            end else if (!has1) begin
              status = ST_EMPTY;
            end else begin
              ovalid  = (op_r == OP_OUT);
              oval    = (op_r == OP_OUT) ? top_r : '0;
              reg_we  = (op_r == OP_POPR);
              mm_we   = (op_r == OP_POPM);
              top_nxt = sec_r;
              dd_nxt  = dd_r - DS_DW'(1);
              fill_nxt = (dd_r > DS_DW'(2)) ? 2'd1 : 2'd0;
              npc     = (op_r == OP_OUT) ? next1 : next2;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (!has2) begin
              status = ST_EMPTY;
            end else if (op_r == OP_DIV && top_r == '0) begin
              status = ST_DIV0;
            end else begin
              npc    = next1;
              dd_nxt = dd_r - DS_DW'(1);
              fill_nxt = (dd_r > DS_DW'(2)) ? 2'd1 : 2'd0;
              case (op_r)
                OP_ADD:  top_nxt = sec_r + top_r;
                OP_SUB:  top_nxt = sec_r - top_r;
                OP_MUL:  top_nxt = sec_r * top_r;
                default: begin
                  ireq.start = 1'b1;
                  state_nxt  = S_ITER;
                end
              endcase
            end
          end
          OP_SQRT: begin
            if (!has1) begin
              status = ST_EMPTY;
            end else if (top_r[31]) begin
              status = ST_NEG;
            end else begin
              npc          = next1;
              ireq.start   = 1'b1;
              ireq.is_sqrt = 1'b1;
              ireq.a       = top_r;
              state_nxt    = S_ITER;
            end
          end
          OP_JMP, OP_JE, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
            cnt_en = 1'b0;
            if (!tgt_ok) begin
              status = ST_INDEX;
            end else if (op_r != OP_JMP && !has2) begin
              status = ST_EMPTY;
            end else begin
              npc = take ? arg_r[PC_W-1:0] : next2;
              if (op_r != OP_JMP) begin
                dd_nxt   = dd_r - DS_DW'(2);
                top_nxt  = ds_rdata;
                fill_nxt = (dd_r > DS_DW'(3)) ? 2'd2 : 2'd0;
              end
            end
          end
          OP_CALL: begin
            cnt_en = 1'b0;
            if (!tgt_ok) begin
              status = ST_INDEX;
            end else if (rd_r == RS_DW'(RETURN_STACK_DEPTH)) begin
              status = ST_RET;
            end else begin
              rs_we  = 1'b1;
              rd_nxt = rd_r + RS_DW'(1);
              npc    = arg_r[PC_W-1:0];
            end
          end
          OP_RET: begin
            cnt_en = 1'b0;
            if (rd_r == '0) begin
              status = ST_RET;
            end else begin
              rd_nxt = rd_r - RS_DW'(1);
              npc    = rs_rdata;
            end
          end
          OP_NOP: npc = next1;
          default: status = ST_INDEX;
        endcase
        if (status != ST_OK) begin
          npc    = pc_r;
          ovalid = 1'b0;
          oval   = '0;
          fill_nxt  = 2'd0;
          state_nxt = S_DONE;
        end else begin
          pc_nxt = npc;
          if (cnt_en) begin
            cc_nxt = cc_r + 32'd1;
          end
        end
        odata_nxt = {2'b00, (status == ST_OK && cnt_en) ? cc_r + 32'd1 : cc_r,
                     status, oval, ovalid, npc};
        if (fill_nxt != 2'd0 && state_nxt == S_DONE) begin
          state_nxt = S_FILL;
        end
      end
      S_ITER: begin
        if (idone) begin
          top_nxt = ires;
          state_nxt = (fill_r != 2'd0) ? S_FILL : S_DONE;
        end
      end
      S_FILL: begin
        // One pop leaves the second slot to refill; a compare pop drops two
        // entries: the top came from RAM already and the second is addressed, then read.
        if (fill_r == 2'd1) begin
          sec_nxt   = ds_rdata;
          state_nxt = S_DONE;
        end else begin
          fill_nxt = 2'd1;
          ds_we    = 1'b0;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      dd_r    <= '0;
      rd_r    <= '0;
      pc_r    <= '0;
      cc_r    <= '0;
      clr_r   <= '0;
      fill_r  <= '0;
      ovld_r  <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      dd_r    <= dd_nxt;
      rd_r    <= rd_nxt;
      pc_r    <= pc_nxt;
      cc_r    <= cc_nxt;
      clr_r   <= clr_nxt;
      fill_r  <= fill_nxt;
      ovld_r  <= ovld_nxt;
      if (reg_we) begin
        regs_r[reg_wa] <= reg_wd;
      end
    end
    top_r   <= top_nxt;
    sec_r   <= sec_nxt;
    odata_r <= odata_nxt;
    if (in_tvalid && in_tready) begin
      op_r    <= in_tdata[4:0];
      arg_r   <= in_tdata[36:5];
      inval_r <= in_tdata[68:37];
    end
  end

endmodule
